>>> rtl/fpa_pkg.sv
`timescale 1ns / 1ps
// Package for the Q24.8 fixed-point ALU: mode codes, widths, the sideband record.
// No dependencies.
package fpa_pkg;

	localparam int FPA_FRAC_BITS = 8;
	localparam int FPA_W         = 32;

	typedef enum logic [3:0] {
		MODE_ADD      = 4'd0,
		MODE_SUB      = 4'd1,
		MODE_MUL      = 4'd2,
		MODE_DIV      = 4'd3,
		MODE_MIN      = 4'd4,
		MODE_MAX      = 4'd5,
		MODE_INC      = 4'd6,
		MODE_DEC      = 4'd7,
		MODE_FROM_INT = 4'd8,
		MODE_TO_INT   = 4'd9
	} mode_t;

	typedef struct packed {
		logic [FPA_W-1:0] res;
		logic             eq;
		logic             lt;
		logic             gt;
		logic             is_div;
		logic             neg;
		logic             dz;
	} side_t;

endpackage

>>> rtl/fpa_mul.sv
`timescale 1ns / 1ps
// Fixed-point multiply: registered magnitude product, then scale and sign fix.
// Depends on fpa_pkg.
module fpa_mul import fpa_pkg::*; #(
	parameter int FRAC_BITS = FPA_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [FPA_W-1:0] a,
	input  logic signed [FPA_W-1:0] b,
	output logic        [FPA_W-1:0] res
);

	logic [FPA_W-1:0]   mag_a, mag_b, scaled;
	logic [2*FPA_W-1:0] prod_s2;
	logic               neg_s2;

	assign mag_a = a[FPA_W-1] ? FPA_W'(-a) : FPA_W'(a);
	assign mag_b = b[FPA_W-1] ? FPA_W'(-b) : FPA_W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= (2*FPA_W)'(mag_a) * (2*FPA_W)'(mag_b);
			neg_s2  <= a[FPA_W-1] ^ b[FPA_W-1];
		end
	end

	assign scaled = prod_s2[FRAC_BITS +: FPA_W];
	assign res    = neg_s2 ? FPA_W'(-scaled) : scaled;

endmodule

>>> rtl/fpa_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with a sideband record.
// Depends on fpa_pkg.
module fpa_div import fpa_pkg::*; #(
	parameter int NUM_W = FPA_W + FPA_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [NUM_W-1:0] num,
	input  logic [FPA_W-1:0] den,
	input  side_t            side_in,
	output logic             vld_out,
	output logic [FPA_W-1:0] quo,
	output side_t            side_out
);

	logic [FPA_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [FPA_W-1:0] den_s [NUM_W];
	side_t            side_s[NUM_W];
	logic             vld_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [FPA_W-1:0] rem_i, den_i, rem_n;
		logic [NUM_W-1:0] nq_i;
		side_t            side_i;
		logic             vld_i;
		logic [FPA_W:0]   trial, diff;
		logic             take;

		if (i == 0) begin : g_first
			assign rem_i  = '0;
			assign nq_i   = num;
			assign den_i  = den;
			assign side_i = side_in;
			assign vld_i  = vld_in;
		end else begin : g_next
			assign rem_i  = rem_s[i-1];
			assign nq_i   = nq_s[i-1];
			assign den_i  = den_s[i-1];
			assign side_i = side_s[i-1];
			assign vld_i  = vld_s[i-1];
		end

		assign trial = {rem_i, nq_i[NUM_W-1]};
		assign diff  = trial - {1'b0, den_i};
		assign take  = trial >= {1'b0, den_i};
		assign rem_n = take ? diff[FPA_W-1:0] : trial[FPA_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= rem_n;
				nq_s[i]   <= {nq_i[NUM_W-2:0], take};
				den_s[i]  <= den_i;
				side_s[i] <= side_i;
			end
		end
	end

	assign vld_out  = vld_s[NUM_W-1];
	assign quo      = nq_s[NUM_W-1][FPA_W-1:0];
	assign side_out = side_s[NUM_W-1];

endmodule

>>> rtl/fixed_point_alu_q24_8.sv
`timescale 1ns / 1ps
// Top level of the signed fixed-point ALU, FRAC_BITS fractional bits.
// Depends on fpa_pkg, fpa_mul, fpa_div.
//
// channel | handshake               | payload
// in      | in_valid / in_stall     | mode, operand_a, operand_b
// out     | out_valid / out_stall   | result_value, is_equal, a_is_less, a_is_greater,
//         |                         | divide_by_zero
//
// One transaction per cycle while the output is not stalled; the divider takes one
// quotient bit per stage (32 + FRAC_BITS stages).
// Every operation runs through the same pipeline, so results leave in order.
// Reset clears the valid bits only.
// A stalled valid output (out_stall while out_valid) freezes the whole pipeline and raises in_stall.
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
	parameter int FRAC_BITS = FPA_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [3:0]              mode,
	input  logic signed [FPA_W-1:0] operand_a,
	input  logic signed [FPA_W-1:0] operand_b,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [FPA_W-1:0] result_value,
	output logic                    is_equal,
	output logic                    a_is_less,
	output logic                    a_is_greater,
	output logic                    divide_by_zero
);

	localparam int NUM_W = FPA_W + FRAC_BITS;

	logic                    adv;
	logic                    vld_s1, vld_s2, out_valid_q;
	logic [3:0]              mode_s1;
	logic signed [FPA_W-1:0] a_s1, b_s1;
	side_t                   side_c, side_s2, side_div, side_out;
	logic [NUM_W-1:0]        num_c, num_s2;
	logic [FPA_W-1:0]        den_c, den_s2, mag_a, mag_b, mul_res, quo, res_fin;
	logic                    is_mul_s2, vld_div;
	side_t                   side_in_div;
	logic [FPA_W-1:0]        res_q;
	logic                    eq_q, lt_q, gt_q, dz_q;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			out_valid_q <= vld_div;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
		end
	end

	assign mag_a = a_s1[FPA_W-1] ? FPA_W'(-a_s1) : FPA_W'(a_s1);
	assign mag_b = b_s1[FPA_W-1] ? FPA_W'(-b_s1) : FPA_W'(b_s1);

	always_comb begin
		side_c        = '0;
		side_c.eq     = a_s1 == b_s1;
		side_c.lt     = a_s1 < b_s1;
		side_c.gt     = a_s1 > b_s1;
		side_c.is_div = mode_s1 == MODE_DIV;
		side_c.neg    = a_s1[FPA_W-1] ^ b_s1[FPA_W-1];
		side_c.dz     = (mode_s1 == MODE_DIV) && (b_s1 == '0);
		num_c         = NUM_W'(mag_a) << FRAC_BITS;
		den_c         = mag_b;
		case (mode_t'(mode_s1))
			MODE_ADD:      side_c.res = FPA_W'(a_s1 + b_s1);
			MODE_SUB:      side_c.res = FPA_W'(a_s1 - b_s1);
			MODE_MIN:      side_c.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			MODE_MAX:      side_c.res = (a_s1 > b_s1) ? a_s1 : b_s1;
			MODE_INC:      side_c.res = FPA_W'(a_s1 + 1);
			MODE_DEC:      side_c.res = FPA_W'(a_s1 - 1);
			MODE_FROM_INT: side_c.res = a_s1 << FRAC_BITS;
			MODE_TO_INT:   side_c.res = a_s1 >>> FRAC_BITS;
			default:       side_c.res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2   <= side_c;
			is_mul_s2 <= mode_s1 == MODE_MUL;
			num_s2    <= num_c;
			den_s2    <= den_c;
		end
	end

	fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk (clk),
		.en  (adv),
		.a   (a_s1),
		.b   (b_s1),
		.res (mul_res)
	);

	always_comb begin
		side_in_div = side_s2;
		if (is_mul_s2) begin
			side_in_div.res = mul_res;
		end
	end

	fpa_div #(.NUM_W(NUM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s2),
		.num      (num_s2),
		.den      (den_s2),
		.side_in  (side_in_div),
		.vld_out  (vld_div),
		.quo      (quo),
		.side_out (side_div)
	);

	assign side_out = side_div;

	always_comb begin
		if (!side_out.is_div) begin
			res_fin = side_out.res;
		end else if (side_out.dz) begin
			res_fin = '0;
		end else if (side_out.neg) begin
			res_fin = FPA_W'(-quo);
		end else begin
			res_fin = quo;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_fin;
			eq_q  <= side_out.eq;
			lt_q  <= side_out.lt;
			gt_q  <= side_out.gt;
			dz_q  <= side_out.dz;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_value   = res_q;
	assign is_equal       = eq_q;
	assign a_is_less      = lt_q;
	assign a_is_greater   = gt_q;
	assign divide_by_zero = dz_q;

`ifndef SYNTH
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({is_equal, a_is_less, a_is_greater}))
		else $error("compare flags not one-hot");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_value == '0)
		else $error("divide by zero with nonzero result");
	a_dz_neq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero && is_equal |-> result_value == '0 && a_is_less == 1'b0)
		else $error("divide by zero flags inconsistent");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value))
		else $error("stalled result lost");
`endif

endmodule
